// ===== rtl/rar_pkg.sv =====
package rar_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;
endpackage

// ===== rtl/rar_divider.sv =====
module rar_divider #(
    parameter int W = 34
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    input  logic signed [W-1:0] divisor,
    output logic                done,
    output logic signed [W-1:0] quotient,
    output logic signed [W-1:0] remainder
);
    import rar_pkg::*;

    localparam int CW = $clog2(W + 1);

    // restoring divide on magnitudes, one bit per cycle; truncating signs
    logic [W-1:0]  mag_n_reg, quo_reg;
    logic [W-1:0]  mag_d_reg;
    logic [W:0]    rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, neg_q_reg, neg_r_reg, done_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb begin
        shifted = {rem_reg[W-1:0], mag_n_reg[W-1]};
        diff    = shifted - {1'b0, mag_d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CW'(W);
                mag_n_reg <= dividend[W-1] ? W'(-dividend) : dividend;
                mag_d_reg <= divisor[W-1] ? W'(-divisor) : divisor;
                neg_q_reg <= dividend[W-1] ^ divisor[W-1];
                neg_r_reg <= dividend[W-1];
                rem_reg   <= '0;
                quo_reg   <= '0;
            end else if (busy_reg) begin
                mag_n_reg <= {mag_n_reg[W-2:0], 1'b0};
                if (!diff[W]) begin
                    rem_reg <= diff;
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? W'(-quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? W'(-rem_reg[W-1:0]) : rem_reg[W-1:0];
endmodule

// ===== rtl/rational_arith_reduce.sv =====
// rational_arith_reduce: a_num/a_den (op) b_num/b_den, reduced by a gcd.
// Input channel s_valid/s_ready carries s_mode and four signed operands;
// result channel m_valid/m_ready carries m_res_num, m_res_den and
// m_zero_den_error. One item is in flight at a time: s_ready is low from
// acceptance until the result has been taken.
// Steps: S_MUL forms the products, S_SUM the numerator and denominator,
// then Euclid's remainder loop and two final divisions, all on one shared
// bit-serial divider of 2*W+2 bits. With W=16 that is 3 to roughly 48
// divisions per item. A zero denominator skips the divider and S_SUM
// sets zeros and the error flag in the output registers.
// Reset (aresetn low, synchronous) drops any item in flight and leaves the
// block idle and ready. When m_ready is low the result is held in its
// output registers and no new item is accepted until it is taken.
module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_mode,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_den,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [2*OPERAND_WIDTH:0]   m_res_num,
    output logic signed [2*OPERAND_WIDTH-1:0] m_res_den,
    output logic                         m_zero_den_error
);
    import rar_pkg::*;

    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int DW = PW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_EUC, S_DIVN, S_DIVD, S_OUT
    } state_t;

    state_t state_reg;
    mode_t  mode_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [DW-1:0] n_reg, d_reg, x_reg, y_reg;
    logic signed [DW-1:0] dv_a, dv_b, quo, rem;
    logic dv_start, dv_done;
    logic valid_reg, err_reg;
    logic signed [PW:0]   res_n_reg;
    logic signed [PW-1:0] res_d_reg;

    rar_divider #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b), .done(dv_done),
        .quotient(quo), .remainder(rem)
    );

    always_comb begin
        dv_start = 1'b0;
        dv_a     = x_reg;
        dv_b     = y_reg;
        unique case (state_reg)
            S_SUM: dv_start = (d_reg != '0);
            S_EUC: begin
                if (dv_done && rem != '0) dv_start = 1'b1;
                if (dv_done) begin
                    dv_a = y_reg;
                    dv_b = rem;
                end
                if (dv_done && rem == '0) begin
                    dv_start = 1'b1;
                    dv_a = n_reg;
                    dv_b = y_reg;
                end
            end
            S_DIVN: begin
                dv_start = dv_done;
                dv_a     = d_reg;
                dv_b     = x_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    mode_reg  <= mode_t'(s_mode);
                    an_reg    <= s_a_num;
                    ad_reg    <= s_a_den;
                    bn_reg    <= s_b_num;
                    bd_reg    <= s_b_den;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    // operands sign-extended first so the products are exact
                    p1_reg <= PW'(an_reg) * PW'(bd_reg);
                    p2_reg <= (mode_reg == MODE_MUL) ? PW'(an_reg) * PW'(bn_reg)
                                                     : PW'(ad_reg) * PW'(bn_reg);
                    p3_reg <= (mode_reg == MODE_DIV) ? PW'(ad_reg) * PW'(bn_reg)
                                                     : PW'(ad_reg) * PW'(bd_reg);
                    state_reg <= S_SUM;
                    d_reg <= '0;
                end
                S_SUM: begin
                    // d computed below; first pass loads n/d, second starts
                    unique case (mode_reg)
                        MODE_ADD: n_reg <= DW'(p1_reg) + DW'(p2_reg);
                        MODE_SUB: n_reg <= DW'(p1_reg) - DW'(p2_reg);
                        MODE_MUL: n_reg <= DW'(p2_reg);
                        default:  n_reg <= DW'(p1_reg);
                    endcase
                    d_reg <= DW'(p3_reg);
                    x_reg <= (mode_reg == MODE_ADD) ? DW'(p1_reg) + DW'(p2_reg) :
                             (mode_reg == MODE_SUB) ? DW'(p1_reg) - DW'(p2_reg) :
                             (mode_reg == MODE_MUL) ? DW'(p2_reg) : DW'(p1_reg);
                    y_reg <= DW'(p3_reg);
                    if (d_reg != '0) state_reg <= S_EUC;
                    else if (p3_reg == '0) begin
                        err_reg   <= 1'b1;
                        res_n_reg <= '0;
                        res_d_reg <= '0;
                        valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_EUC: if (dv_done) begin
                    if (rem != '0) begin
                        x_reg <= y_reg;
                        y_reg <= rem;
                    end else begin
                        x_reg     <= y_reg;
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN: if (dv_done) begin
                    res_n_reg <= quo[PW:0];
                    state_reg <= S_DIVD;
                end
                S_DIVD: if (dv_done) begin
                    res_d_reg <= quo[PW-1:0];
                    err_reg   <= 1'b0;
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_ready) begin
                    valid_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = valid_reg;
    assign m_res_num        = res_n_reg;
    assign m_res_den        = res_d_reg;
    assign m_zero_den_error = err_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_num))
        else $error("result dropped under stall");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_den_error |-> m_res_num == '0 && m_res_den == '0)
        else $error("error item carries nonzero fields");
`endif
endmodule
